/* sv/fcqi_pkg.sv */
// ----------------------------------------------------------------------------
// Fully connected q7 interleaved: shared types and constants
// Item types, operation and register codes, and sizes of the stores and the
// result queue.
// ----------------------------------------------------------------------------
package fcqi_pkg;

  localparam int MAX_VECTOR = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int VEC_AW     = $clog2(MAX_VECTOR);
  localparam int ROW_AW     = $clog2(MAX_ROWS);
  localparam int SIZE_W     = 11;
  localparam int GROUP_ROWS = 4;
  localparam int BANK_AW    = ROW_AW - 2;
  localparam int GRP_W      = ROW_AW - 2;
  localparam int OFF_W      = VEC_AW + 2;
  localparam int DATA_W     = 8;
  localparam int SUM_W      = 32;
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_VECTOR = 2'd0,
    OP_BIAS   = 2'd1,
    OP_WEIGHT = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_VECTOR_LENGTH = 3'd0,
    CFG_ROW_COUNT     = 3'd1,
    CFG_BIAS_SHIFT    = 3'd2,
    CFG_OUTPUT_SHIFT  = 3'd3,
    CFG_BIAS_ENABLE   = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [ROW_AW-1:0]        row_index;
    logic                     last_row;
  } out_item_t;

  typedef struct packed {
    logic              vec_wr;
    logic [VEC_AW-1:0] vec_addr;
    logic              bias_wr;
    logic [ROW_AW-1:0] bias_addr;
    logic              weight;
    logic [VEC_AW-1:0] col;
    logic [1:0]        lane;
    logic              start_all;
    logic              start_one;
    logic              emit;
    logic              emit_four;
    logic [ROW_AW-1:0] row;
    logic              last;
  } seq_ctrl_t;

  typedef struct packed {
    logic valid;
    logic four;
  } fifo_push_t;

endpackage

/* sv/fcqi_seq.sv */
// ----------------------------------------------------------------------------
// Fully connected q7 interleaved: load pointers and weight position
// Tracks where the next vector element, bias and weight belong, and marks the
// first and last weight of each row group or leftover row.
// ----------------------------------------------------------------------------
module fcqi_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [1:0]                   operation_i,
  input  logic [fcqi_pkg::SIZE_W-1:0]  len_i,
  input  logic [fcqi_pkg::SIZE_W-1:0]  rows_i,
  input  logic                         clear_i,
  output fcqi_pkg::seq_ctrl_t          ctrl_o
);

  logic [fcqi_pkg::VEC_AW-1:0] vptr_q;
  logic [fcqi_pkg::ROW_AW-1:0] bptr_q;
  logic                        tail_q;
  logic [fcqi_pkg::GRP_W-1:0]  grp_q;
  logic [fcqi_pkg::OFF_W-1:0]  off_q;
  logic [fcqi_pkg::ROW_AW-1:0] trow_q;
  logic [fcqi_pkg::VEC_AW-1:0] tcol_q;

  logic [fcqi_pkg::GRP_W:0]    groups;
  logic [fcqi_pkg::GRP_W:0]    blocks;
  logic                        in_tail;
  logic                        in_block;
  logic [fcqi_pkg::OFF_W:0]    gsize_m1;
  logic                        full_end;
  logic                        grp_last;
  logic                        tail_end;
  logic                        trow_last;
  logic                        is_weight;
  logic                        vec_wr;
  logic                        bias_wr;
  logic [fcqi_pkg::VEC_AW-1:0] vptr_d;
  logic [fcqi_pkg::ROW_AW-1:0] bptr_d;

  assign groups    = rows_i[fcqi_pkg::SIZE_W-1:2];
  assign blocks    = len_i[fcqi_pkg::SIZE_W-1:2];
  assign in_tail   = tail_q || (groups == '0);
  assign in_block  = {1'b0, off_q[fcqi_pkg::OFF_W-1:4]} < blocks;
  assign gsize_m1  = {len_i, 2'b00} - 13'd1;
  assign full_end  = {1'b0, off_q} == gsize_m1;
  assign grp_last  = {1'b0, grp_q} == (groups - 9'd1);
  assign tail_end  = {1'b0, tcol_q} == (len_i - 11'd1);
  assign trow_last = {1'b0, trow_q} == (rows_i - 11'd1);

  assign vec_wr    = accept_i && (operation_i == fcqi_pkg::OP_VECTOR);
  assign bias_wr   = accept_i && (operation_i == fcqi_pkg::OP_BIAS);
  assign is_weight = accept_i && (operation_i == fcqi_pkg::OP_WEIGHT) &&
                     (len_i != '0) && (rows_i != '0);

  assign vptr_d = (({1'b0, vptr_q} + 11'd1) >= len_i) ? '0 : vptr_q + 10'd1;
  assign bptr_d = (({1'b0, bptr_q} + 11'd1) >= rows_i) ? '0 : bptr_q + 10'd1;

  always_comb begin
    ctrl_o.vec_wr    = vec_wr;
    ctrl_o.vec_addr  = vptr_q;
    ctrl_o.bias_wr   = bias_wr;
    ctrl_o.bias_addr = bptr_q;
    ctrl_o.weight    = is_weight;
    if (in_tail) begin
      ctrl_o.col  = tcol_q;
      ctrl_o.lane = 2'd0;
      ctrl_o.row  = trow_q;
      ctrl_o.last = trow_last;
    end else begin
      if (in_block) begin
        ctrl_o.col  = {off_q[fcqi_pkg::OFF_W-1:4], off_q[1], off_q[3]};
        ctrl_o.lane = {off_q[2], off_q[0]};
      end else begin
        ctrl_o.col  = off_q[fcqi_pkg::OFF_W-1:2];
        ctrl_o.lane = off_q[1:0];
      end
      ctrl_o.row  = {grp_q, 2'b00};
      ctrl_o.last = (rows_i[1:0] == 2'd0) && grp_last;
    end
    ctrl_o.start_all = is_weight && !in_tail && (off_q == '0);
    ctrl_o.start_one = is_weight && in_tail && (tcol_q == '0);
    ctrl_o.emit      = is_weight && (in_tail ? tail_end : full_end);
    ctrl_o.emit_four = !in_tail;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vptr_q <= '0;
      bptr_q <= '0;
      tail_q <= 1'b0;
      grp_q  <= '0;
      off_q  <= '0;
      trow_q <= '0;
      tcol_q <= '0;
    end else if (clear_i) begin
      vptr_q <= '0;
      bptr_q <= '0;
      tail_q <= 1'b0;
      grp_q  <= '0;
      off_q  <= '0;
      trow_q <= '0;
      tcol_q <= '0;
    end else begin
      if (vec_wr) begin
        vptr_q <= vptr_d;
      end
      if (bias_wr) begin
        bptr_q <= bptr_d;
      end
      if (is_weight) begin
        if (in_tail) begin
          if (tail_end) begin
            tcol_q <= '0;
            if (trow_last) begin
              tail_q <= 1'b0;
              trow_q <= '0;
              grp_q  <= '0;
              off_q  <= '0;
            end else begin
              trow_q <= trow_q + 10'd1;
            end
          end else begin
            tcol_q <= tcol_q + 10'd1;
          end
        end else begin
          if (full_end) begin
            off_q <= '0;
            if (grp_last) begin
              grp_q <= '0;
              if (rows_i[1:0] != 2'd0) begin
                tail_q <= 1'b1;
                trow_q <= {rows_i[fcqi_pkg::ROW_AW-1:2], 2'b00};
                tcol_q <= '0;
              end
            end else begin
              grp_q <= grp_q + 8'd1;
            end
          end else begin
            off_q <= off_q + 12'd1;
          end
        end
      end
    end
  end

endmodule

/* sv/fcqi_fifo.sv */
// ----------------------------------------------------------------------------
// Fully connected q7 interleaved: result queue
// Takes one or four results in a cycle and hands them out one per item.
// ----------------------------------------------------------------------------
module fcqi_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fcqi_pkg::fifo_push_t        push_i,
  input  fcqi_pkg::out_item_t [3:0]   items_i,
  input  logic                        pop_i,
  output logic                        valid_o,
  output fcqi_pkg::out_item_t         item_o
);

  fcqi_pkg::out_item_t          mem_q [fcqi_pkg::FIFO_DEPTH];
  logic [fcqi_pkg::FIFO_AW-1:0] wptr_q;
  logic [fcqi_pkg::FIFO_AW-1:0] rptr_q;
  logic [fcqi_pkg::OCC_W-1:0]   count_q;
  logic [fcqi_pkg::OCC_W-1:0]   push_n;

  assign push_n  = push_i.valid ? (push_i.four ? 6'd4 : 6'd1) : 6'd0;
  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      for (int i = 0; i < 4; i++) begin
        if (push_i.four || (i == 0)) begin
          mem_q[wptr_q + 5'(i)] <= items_i[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + push_n[fcqi_pkg::FIFO_AW-1:0];
      rptr_q  <= rptr_q + 5'(pop_i);
      count_q <= count_q + push_n - 6'(pop_i);
    end
  end

endmodule

/* sv/fully_connected_q7_interleaved.sv */
// ----------------------------------------------------------------------------
// Fully connected q7 interleaved: top level
// Loads an 8-bit vector and per-row biases, then multiply-accumulates a
// stream of interleaved weights and emits one saturated 8-bit value per row.
// ----------------------------------------------------------------------------
// Items enter on the in channel (valid, stall, struct payload): vector
// elements, biases and weights. Results leave on the out channel, one row per
// item. The user must write registers through the cfg port only while the
// block is idle; the block itself does not enforce this.
// One input item is accepted every cycle while in stall is low. A weight
// flows through a store read stage, a multiply stage and the accumulator, and
// its finished rows enter a 32-entry result queue once the last weight of the
// row group leaves the accumulator. A group of four rows pushes four results
// at once, which then leave at one per cycle while out stall is low.
//
// Reset sets both sizes to one, both shifts to zero, biases off, all
// pointers and sums to zero and empties the queue. The vector and bias stores
// hold unknown data until loaded.
//
// When the receiver stalls, results wait in the queue. Input stall rises once
// more than 28 queue slots are filled or promised to items in flight.
// ----------------------------------------------------------------------------
module fully_connected_q7_interleaved (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  fcqi_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output fcqi_pkg::out_item_t                  out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [2:0]                           cfg_index_i,
  input  logic [fcqi_pkg::SIZE_W-1:0]          cfg_data_i
);

  logic [fcqi_pkg::SIZE_W-1:0] vec_len_q;
  logic [fcqi_pkg::SIZE_W-1:0] row_cnt_q;
  logic [4:0]                  bias_shift_q;
  logic [4:0]                  out_shift_q;
  logic                        bias_en_q;

  logic                        cfg_wr;
  logic                        size_clear;
  logic [fcqi_pkg::SIZE_W-1:0] len_eff;
  logic [fcqi_pkg::SIZE_W-1:0] rows_eff;
  logic                        accept;
  fcqi_pkg::seq_ctrl_t         ctrl;

  logic signed [fcqi_pkg::DATA_W-1:0] vmem [fcqi_pkg::MAX_VECTOR];
  logic signed [fcqi_pkg::DATA_W-1:0] bmem [4][2**fcqi_pkg::BANK_AW];
  logic signed [fcqi_pkg::DATA_W-1:0] vec_rd_q;
  logic signed [fcqi_pkg::DATA_W-1:0] bias_rd_q [4];

  logic                               w1_q, sa1_q, so1_q, em1_q, four1_q;
  logic signed [fcqi_pkg::DATA_W-1:0] d1_q;
  logic [1:0]                         lane1_q;
  logic [fcqi_pkg::ROW_AW-1:0]        row1_q;
  logic                               last1_q;

  logic [fcqi_pkg::SUM_W-1:0]         round_val;
  logic [fcqi_pkg::SUM_W-1:0]         init1 [4];

  logic                               w2_q, sa2_q, so2_q, em2_q, four2_q;
  logic signed [2*fcqi_pkg::DATA_W-1:0] p2_q;
  logic [fcqi_pkg::SUM_W-1:0]         init2_q [4];
  logic [1:0]                         lane2_q;
  logic [fcqi_pkg::ROW_AW-1:0]        row2_q;
  logic                               last2_q;

  logic [fcqi_pkg::SUM_W-1:0]         sums_q [4];
  logic [fcqi_pkg::SUM_W-1:0]         sums_d [4];
  logic                               em3_q, four3_q;
  logic [fcqi_pkg::ROW_AW-1:0]        row3_q;
  logic                               last3_q;

  fcqi_pkg::out_item_t [3:0]          items;
  fcqi_pkg::fifo_push_t               push;
  logic                               pop;
  logic [fcqi_pkg::OCC_W-1:0]         occ_q;
  logic [fcqi_pkg::OCC_W-1:0]         reserve;

  function automatic logic signed [7:0] finish(input logic [31:0] sum,
                                               input logic [4:0] sh);
    logic signed [31:0] y;
    logic signed [7:0]  r;
    y = $signed(sum) >>> sh;
    if (y > 32'sd127) begin
      r = 8'sd127;
    end else if (y < -32'sd128) begin
      r = -8'sd128;
    end else begin
      r = y[7:0];
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign size_clear  = cfg_wr && ((cfg_index_i == fcqi_pkg::CFG_VECTOR_LENGTH) ||
                                  (cfg_index_i == fcqi_pkg::CFG_ROW_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_len_q    <= 11'd1;
      row_cnt_q    <= 11'd1;
      bias_shift_q <= '0;
      out_shift_q  <= '0;
      bias_en_q    <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        fcqi_pkg::CFG_VECTOR_LENGTH: vec_len_q    <= cfg_data_i;
        fcqi_pkg::CFG_ROW_COUNT:     row_cnt_q    <= cfg_data_i;
        fcqi_pkg::CFG_BIAS_SHIFT:    bias_shift_q <= cfg_data_i[4:0];
        fcqi_pkg::CFG_OUTPUT_SHIFT:  out_shift_q  <= cfg_data_i[4:0];
        fcqi_pkg::CFG_BIAS_ENABLE:   bias_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign len_eff  = (vec_len_q > 11'(fcqi_pkg::MAX_VECTOR)) ?
                    11'(fcqi_pkg::MAX_VECTOR) : vec_len_q;
  assign rows_eff = (row_cnt_q > 11'(fcqi_pkg::MAX_ROWS)) ?
                    11'(fcqi_pkg::MAX_ROWS) : row_cnt_q;

  assign accept     = in_valid_i && !in_stall_o;
  assign reserve    = ctrl.emit ? (ctrl.emit_four ? 6'd4 : 6'd1) : 6'd0;
  assign pop        = out_valid_o && !out_stall_i;
  assign in_stall_o = occ_q > 6'(fcqi_pkg::FIFO_DEPTH - 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + reserve - 6'(pop);
    end
  end

  fcqi_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (in_data_i.operation),
    .len_i       (len_eff),
    .rows_i      (rows_eff),
    .clear_i     (size_clear),
    .ctrl_o      (ctrl)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.vec_wr) begin
      vmem[ctrl.vec_addr] <= in_data_i.data_value;
    end
    vec_rd_q <= vmem[ctrl.col];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      if (ctrl.bias_wr && (ctrl.bias_addr[1:0] == 2'(i))) begin
        bmem[i][ctrl.bias_addr[fcqi_pkg::ROW_AW-1:2]] <= in_data_i.data_value;
      end
      bias_rd_q[i] <= bmem[i][ctrl.row[fcqi_pkg::ROW_AW-1:2]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q    <= 1'b0;
      sa1_q   <= 1'b0;
      so1_q   <= 1'b0;
      em1_q   <= 1'b0;
      four1_q <= 1'b0;
    end else begin
      w1_q    <= ctrl.weight;
      sa1_q   <= ctrl.start_all;
      so1_q   <= ctrl.start_one;
      em1_q   <= ctrl.emit;
      four1_q <= ctrl.emit_four;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q    <= in_data_i.data_value;
    lane1_q <= ctrl.lane;
    row1_q  <= ctrl.row;
    last1_q <= ctrl.last;
  end

  assign round_val = (out_shift_q == '0) ? '0 : (32'd1 << (out_shift_q - 5'd1));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic signed [7:0] b;
      b = four1_q ? bias_rd_q[i] : bias_rd_q[row1_q[1:0]];
      init1[i] = round_val +
                 (bias_en_q ? ({{24{b[7]}}, b} << bias_shift_q) : 32'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w2_q    <= 1'b0;
      sa2_q   <= 1'b0;
      so2_q   <= 1'b0;
      em2_q   <= 1'b0;
      four2_q <= 1'b0;
    end else begin
      w2_q    <= w1_q;
      sa2_q   <= sa1_q;
      so2_q   <= so1_q;
      em2_q   <= em1_q;
      four2_q <= four1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_q    <= d1_q * vec_rd_q;
    init2_q <= init1;
    lane2_q <= lane1_q;
    row2_q  <= row1_q;
    last2_q <= last1_q;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [31:0] base;
      logic [31:0] addend;
      base   = (sa2_q || (so2_q && (i == 0))) ? init2_q[i] : sums_q[i];
      addend = (lane2_q == 2'(i)) ? {{16{p2_q[15]}}, p2_q} : 32'd0;
      sums_d[i] = w2_q ? (base + addend) : sums_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        sums_q[i] <= '0;
      end
      em3_q   <= 1'b0;
      four3_q <= 1'b0;
    end else begin
      sums_q  <= sums_d;
      em3_q   <= em2_q;
      four3_q <= four2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    row3_q  <= row2_q;
    last3_q <= last2_q;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      items[i].result_value = finish(sums_q[i], out_shift_q);
      if (four3_q) begin
        items[i].row_index = {row3_q[fcqi_pkg::ROW_AW-1:2], 2'(i)};
        items[i].last_row  = last3_q && (i == 3);
      end else begin
        items[i].row_index = row3_q;
        items[i].last_row  = last3_q;
      end
    end
    push.valid = em3_q;
    push.four  = four3_q;
  end

  fcqi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .items_i (items),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .item_o  (out_data_o)
  );

endmodule

/* sv/fcqi_checker.sv */
// ----------------------------------------------------------------------------
// Fully connected q7 interleaved: port checker
// Watches the top level ports and tracks the row count written over the
// configuration port.
// ----------------------------------------------------------------------------
module fcqi_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input fcqi_pkg::out_item_t          out_data_o,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [2:0]                   cfg_index_i,
  input logic [fcqi_pkg::SIZE_W-1:0]  cfg_data_i
);

  logic [fcqi_pkg::SIZE_W-1:0] rows_q;
  logic [fcqi_pkg::SIZE_W-1:0] rows_eff;
  logic                        in_accept;

  assign in_accept = in_valid_i && !in_stall_o;
  assign rows_eff  = (rows_q > 11'(fcqi_pkg::MAX_ROWS)) ? 11'(fcqi_pkg::MAX_ROWS) : rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 11'd1;
    end else if (cfg_valid_i && cfg_ready_o &&
                 (cfg_index_i == fcqi_pkg::CFG_ROW_COUNT)) begin
      rows_q <= cfg_data_i;
    end
  end

  a_stall_has_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_last_row_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_row |->
      ({1'b0, out_data_o.row_index} == (rows_eff - 11'd1)))
    else $error("last row flag on a row that is not the final one");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_data_o.row_index} < rows_eff))
    else $error("result row index beyond the row count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  a_no_accept_in_reset_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result offered right after reset");

  logic unused_accept;
  assign unused_accept = in_accept;

endmodule

bind fully_connected_q7_interleaved fcqi_checker u_fcqi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i),
  .cfg_data_i  (cfg_data_i)
);

/* tb/tb_fully_connected_q7_interleaved.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fully connected q7 interleaved: testbench
// Loads vectors and biases, streams interleaved weights and checks every row
// result against a cycle-free testbench model of the layer. Runs directed
// cases, then random products in three idle patterns, size limits after one.
// ----------------------------------------------------------------------------
module tb_fully_connected_q7_interleaved;

  import fcqi_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [2:0]        cfg_index_i = '0;
  logic [SIZE_W-1:0] cfg_data_i  = '0;

  // Model state of the layer.
  logic [SIZE_W-1:0]        cfg_len;
  logic [SIZE_W-1:0]        cfg_rows;
  logic [4:0]               bias_shift;
  logic [4:0]               out_shift;
  logic                     bias_en;
  logic signed [DATA_W-1:0] vec_mem  [MAX_VECTOR];
  logic signed [DATA_W-1:0] bias_mem [MAX_ROWS];
  logic [SUM_W-1:0]         sums     [4];
  int unsigned              vptr;
  int unsigned              bptr;
  int unsigned              wpos;

  out_item_t   expected_rows [$];
  out_item_t   want_row;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  fully_connected_q7_interleaved i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [SUM_W-1:0] start_sum(int unsigned row);
    logic [SUM_W-1:0] s;
    int b;
    s = (out_shift == 0) ? 32'd0 : (32'd1 << (out_shift - 5'd1));
    if (bias_en) begin
      b = bias_mem[row];
      s = s + (b << bias_shift);
    end
    return s;
  endfunction

  function automatic out_item_t row_result(logic [SUM_W-1:0] sum, int unsigned row,
                                           bit last);
    out_item_t res;
    int y;
    y = $signed(sum) >>> out_shift;
    if (y > 127) begin
      res.result_value = 8'sd127;
    end else if (y < -128) begin
      res.result_value = -8'sd128;
    end else begin
      res.result_value = y[7:0];
    end
    res.row_index = row[ROW_AW-1:0];
    res.last_row  = last;
    return res;
  endfunction

  task automatic predict_rows(in_item_t it);
    int unsigned len, rows, p, gsize, full, total, g, off, blocks, k, r, col, q, row;
    int v, d, i;
    d    = $signed(it.data_value);
    len  = (cfg_len > MAX_VECTOR) ? MAX_VECTOR : cfg_len;
    rows = (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
    case (it.operation)
      OP_VECTOR: begin
        vec_mem[vptr] = it.data_value;
        vptr = (vptr + 1 >= len) ? 0 : vptr + 1;
      end
      OP_BIAS: begin
        bias_mem[bptr] = it.data_value;
        bptr = (bptr + 1 >= rows) ? 0 : bptr + 1;
      end
      OP_WEIGHT: begin
        if (len != 0 && rows != 0) begin
          p     = wpos;
          gsize = 4 * len;
          full  = (rows >> 2) * gsize;
          total = rows * len;
          if (p >= total) p = 0;
          if (p < full) begin
            g      = p / gsize;
            off    = p % gsize;
            blocks = len >> 2;
            if (off == 0) begin
              for (i = 0; i < 4; i++) sums[i] = start_sum(4 * g + i);
            end
            if (off < 16 * blocks) begin
              k   = off & 15;
              r   = 2 * ((k >> 2) & 1) + (k & 1);
              col = 4 * (off >> 4) + ((k >> 3) & 1) + 2 * ((k >> 1) & 1);
            end else begin
              q   = off - 16 * blocks;
              r   = q & 3;
              col = 4 * blocks + (q >> 2);
            end
            v = vec_mem[col];
            sums[r] = sums[r] + v * d;
            if (off == gsize - 1) begin
              for (i = 0; i < 4; i++) begin
                row = 4 * g + i;
                expected_rows.push_back(row_result(sums[i], row, row == rows - 1));
              end
            end
          end else begin
            q   = p - full;
            row = (rows & ~32'd3) + q / len;
            col = q % len;
            if (col == 0) sums[0] = start_sum(row);
            v = vec_mem[col];
            sums[0] = sums[0] + v * d;
            if (col == len - 1) begin
              expected_rows.push_back(row_result(sums[0], row, row == rows - 1));
            end
          end
          p++;
          wpos = (p >= total) ? 0 : p;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rows.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: value %0d row %0d last %0b", $time,
                 out_data_o.result_value, out_data_o.row_index, out_data_o.last_row);
      end else begin
        want_row = expected_rows.pop_front();
        if (out_data_o.result_value !== want_row.result_value ||
            out_data_o.row_index !== want_row.row_index ||
            out_data_o.last_row !== want_row.last_row) begin
          error_count++;
          $display("%0t: mismatch: expected value %0d row %0d last %0b, actual value %0d row %0d last %0b",
                   $time, want_row.result_value, want_row.row_index, want_row.last_row,
                   out_data_o.result_value, out_data_o.row_index, out_data_o.last_row);
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_item(logic [1:0] op, logic [DATA_W-1:0] data);
    in_item_t it;
    it.operation  = op;
    it.data_value = data;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_rows(it);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(logic [SIZE_W-1:0] len, logic [SIZE_W-1:0] rows,
                           logic [4:0] bsh, logic [4:0] osh, logic ben);
    cfg_index_e        regs [5];
    logic [SIZE_W-1:0] vals [5];
    int i;
    regs = '{CFG_VECTOR_LENGTH, CFG_ROW_COUNT, CFG_BIAS_SHIFT, CFG_OUTPUT_SHIFT,
             CFG_BIAS_ENABLE};
    vals = '{len, rows, SIZE_W'(bsh), SIZE_W'(osh), SIZE_W'(ben)};
    wait_idle();
    for (i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (regs[i])
        CFG_VECTOR_LENGTH: cfg_len    = vals[i];
        CFG_ROW_COUNT:     cfg_rows   = vals[i];
        CFG_BIAS_SHIFT:    bias_shift = vals[i][4:0];
        CFG_OUTPUT_SHIFT:  out_shift  = vals[i][4:0];
        default:           bias_en    = vals[i][0];
      endcase
      if (regs[i] == CFG_VECTOR_LENGTH || regs[i] == CFG_ROW_COUNT) begin
        vptr = 0;
        bptr = 0;
        wpos = 0;
      end
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_operands(int unsigned n_vec, int unsigned n_bias);
    repeat (n_vec) send_item(OP_VECTOR, 8'($urandom_range(255)));
    repeat (n_bias) send_item(OP_BIAS, 8'($urandom_range(255)));
  endtask

  task automatic test_field_extremes();
    configure(1, 1, 31, 31, 1);
    send_item(OP_VECTOR, 8'h80);
    send_item(OP_BIAS, 8'h80);
    send_item(OP_WEIGHT, 8'h80);
    send_item(OP_WEIGHT, 8'h7f);
    configure(1, 1, 0, 0, 1);
    send_item(OP_WEIGHT, 8'h7f);
    send_item(OP_WEIGHT, 8'h80);
    send_item(OP_UNUSED, 8'h55);
    send_item(OP_UNUSED, 8'haa);
    send_item(OP_VECTOR, 8'h7f);
    send_item(OP_WEIGHT, 8'h7f);
  endtask

  task automatic test_interleaved_group();
    configure(4, 4, 3, 2, 1);
    load_operands(4, 4);
    repeat (16) send_item(OP_WEIGHT, 8'($urandom_range(255)));
  endtask

  task automatic test_zero_sizes();
    configure(0, 3, 0, 0, 0);
    send_item(OP_VECTOR, 8'h11);
    send_item(OP_WEIGHT, 8'h22);
    configure(3, 0, 0, 0, 0);
    send_item(OP_BIAS, 8'h33);
    send_item(OP_WEIGHT, 8'h44);
  endtask

  task automatic test_size_rewrite();
    configure(3, 1, 0, 1, 0);
    load_operands(3, 1);
    repeat (2) send_item(OP_WEIGHT, 8'($urandom_range(255)));
    configure(3, 1, 0, 1, 0);
    repeat (3) send_item(OP_WEIGHT, 8'($urandom_range(255)));
  endtask

  task automatic test_size_limits();
    configure(2047, 1, 5, 12, 1);
    load_operands(MAX_VECTOR, 1);
    repeat (MAX_VECTOR) send_item(OP_WEIGHT, 8'($urandom_range(255)));
    configure(1, 1024, 2, 3, 1);
    load_operands(1, MAX_ROWS);
    repeat (MAX_ROWS) send_item(OP_WEIGHT, 8'($urandom_range(255)));
  endtask

  task automatic test_random_products(int unsigned idle_pct, int unsigned busy_pct,
                                      int unsigned n_items);
    int unsigned target, len, rows, total, n_w, n_prod, w;
    send_idle_pct = idle_pct;
    stall_pct     = busy_pct;
    target        = items_sent + n_items;
    while (items_sent < target) begin
      len  = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 9);
      rows = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 9);
      configure(len, rows,
                ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(8),
                ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(12),
                $urandom_range(1));
      load_operands(len, rows);
      total  = len * rows;
      n_prod = $urandom_range(1, 2);
      repeat (n_prod) begin
        n_w = (total == 0) ? 3 : total;
        if ($urandom_range(9) == 0) n_w = $urandom_range(n_w);
        for (w = 0; w < n_w; w++) begin
          if ($urandom_range(99) < 8) begin
            case ($urandom_range(2))
              0:       send_item(OP_UNUSED, 8'($urandom_range(255)));
              1:       send_item(OP_VECTOR, 8'($urandom_range(255)));
              default: send_item(OP_BIAS, 8'($urandom_range(255)));
            endcase
          end
          send_item(OP_WEIGHT, 8'($urandom_range(255)));
        end
      end
    end
  endtask

  initial begin
    cfg_len    = 1;
    cfg_rows   = 1;
    bias_shift = 0;
    out_shift  = 0;
    bias_en    = 0;
    vptr       = 0;
    bptr       = 0;
    wpos       = 0;
    for (int i = 0; i < 4; i++) sums[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 22;
    stall_pct     = 51;
    test_field_extremes();
    test_interleaved_group();
    test_zero_sizes();
    test_size_rewrite();
    test_random_products(22, 51, 85);
    test_size_limits();
    test_random_products(51, 22, 85);
    test_random_products(0, 0, 85);
    wait_idle();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
